// ----- rtl/core/mbpm_pkg.sv -----
// Shared constants and types for the masked byte pattern matcher.
package mbpm_pkg;

    localparam int DATA_W     = 8;   // one region byte
    localparam int SIG_REG_W  = 64;  // one signature register, eight bytes
    localparam int SIG_BYTES  = 32;  // bytes held by the four signature registers
    localparam int CARE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int OUT_OFF_W  = 32;  // width of the reported offset
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_A  = 3'd0,
        CFG_SIG_B  = 3'd1,
        CFG_SIG_C  = 3'd2,
        CFG_SIG_D  = 3'd3,
        CFG_CARE   = 3'd4,
        CFG_LENGTH = 3'd5
    } cfg_idx_t;

endpackage

// ----- rtl/core/mbpm_cfg.sv -----
// Configuration registers and window-aligned signature/care mask.
module mbpm_cfg #(
    parameter int MAX_SIGNATURE = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    input  logic [mbpm_pkg::CFG_IDX_W-1:0]           cfg_addr,
    input  logic [mbpm_pkg::CFG_DATA_W-1:0]          cfg_data,
    // aligned[k] is compared against the byte that arrived k requests ago
    output logic [MAX_SIGNATURE-1:0][mbpm_pkg::DATA_W-1:0] pat_aligned,
    output logic [MAX_SIGNATURE-1:0]                 care_aligned,
    output logic [mbpm_pkg::LEN_W-1:0]               sig_len
);
    import mbpm_pkg::*;

    logic [SIG_REG_W-1:0] sig_a_reg, sig_b_reg, sig_c_reg, sig_d_reg;
    logic [CARE_W-1:0]    care_reg;
    logic [LEN_W-1:0]     len_reg;

    logic [SIG_BYTES-1:0][DATA_W-1:0] sig_all;
    logic [LEN_W-1:0]                 len_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_a_reg <= '0;
            sig_b_reg <= '0;
            sig_c_reg <= '0;
            sig_d_reg <= '0;
            care_reg  <= '0;
            len_reg   <= LEN_W'(1);
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_SIG_A:  sig_a_reg <= cfg_data;
                CFG_SIG_B:  sig_b_reg <= cfg_data;
                CFG_SIG_C:  sig_c_reg <= cfg_data;
                CFG_SIG_D:  sig_d_reg <= cfg_data;
                CFG_CARE:   care_reg  <= cfg_data[CARE_W-1:0];
                CFG_LENGTH: len_reg   <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign sig_all = {sig_d_reg, sig_c_reg, sig_b_reg, sig_a_reg};

    // zero acts as one, oversize clamps to the window depth
    always_comb begin
        if (len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_SIGNATURE)) begin
            len_eff = LEN_W'(MAX_SIGNATURE);
        end else begin
            len_eff = len_reg;
        end
    end

    assign sig_len = len_eff;

    // Oldest byte of the match sits at window slot len-1, so slot k holds
    // signature byte len-1-k. Slots past the length are don't-care.
    always_comb begin
        logic [LEN_W-1:0] j;
        for (int k = 0; k < MAX_SIGNATURE; k++) begin
            j               = len_eff - LEN_W'(1) - LEN_W'(k);
            pat_aligned[k]  = sig_all[j[4:0]];
            care_aligned[k] = care_reg[j[4:0]] && (LEN_W'(k) < len_eff);
        end
    end

endmodule

// ----- rtl/core/masked_byte_pattern_matcher.sv -----
// Top level of the masked byte pattern matcher.
//
// Usage: region bytes arrive one per request on the s_ stream (tdata =
// byte, tlast = last byte of the region). Each byte shifts into a
// window of MAX_SIGNATURE bytes; the window is compared in parallel with
// the configured signature, wildcard positions (care bit clear) matching
// anything. The first match of a region produces a result on the m_
// stream: tuser = found, tdata = start offset within the region, tlast =
// the result came on the region's last byte. A region that ends with no
// match gives found = 0, offset 0, tlast = 1. Later matches are dropped.
// Throughput: one byte per cycle. Latency: a result appears in the cycle
// after its byte is accepted; the window compare and offset subtract sit
// between the window/counter registers and the result register.
// Backpressure: a single result register; s_tready stays high while it
// is empty or being drained, so a stalled receiver only stops input when
// a result is actually waiting.
// Configuration: cfg_valid/cfg_addr/cfg_data, always ready; write only
// while idle. Reset (aresetn low, synchronous) clears the registers to
// zero, signature length to 1, and drops any pending result.
module masked_byte_pattern_matcher #(
    parameter int MAX_SIGNATURE = 32,
    parameter int OFFSET_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input bytes
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbpm_pkg::DATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // region_end
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbpm_pkg::OUT_OFF_W-1:0]    m_tdata,   // [31:0] match_offset
    output logic                              m_tuser,   // [0] found
    output logic                              m_tlast,   // closes_region
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbpm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [mbpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mbpm_pkg::*;

    localparam int OFF_EXT_W = (OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    logic [MAX_SIGNATURE-1:0][DATA_W-1:0] pat_aligned;
    logic [MAX_SIGNATURE-1:0]             care_aligned;
    logic [LEN_W-1:0]                     sig_len;

    mbpm_cfg #(
        .MAX_SIGNATURE(MAX_SIGNATURE)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .pat_aligned  (pat_aligned),
        .care_aligned (care_aligned),
        .sig_len      (sig_len)
    );

    assign cfg_ready = 1'b1;

    // Window holds no reset: the byte count keeps stale slots out of any compare.
    logic [MAX_SIGNATURE-1:0][DATA_W-1:0] win_reg, win_next;
    logic [OFFSET_BITS-1:0]               cnt_reg, cnt_next;
    logic                                 reported_reg, reported_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   found_reg, found_next;
    logic [OUT_OFF_W-1:0]   off_reg, off_next;
    logic                   closes_reg, closes_next;

    logic                   accept;
    logic                   was_sat;
    logic [OFFSET_BITS-1:0] cnt_inc;
    logic [MAX_SIGNATURE-1:0] slot_ok;
    logic                   win_match;
    logic                   hit;
    logic                   miss_end;
    logic [OFFSET_BITS-1:0] off_raw;
    logic [OFF_EXT_W-1:0]   off_ext;
    logic [OUT_OFF_W-1:0]   off_out;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // window as it stands once the new byte is in
    always_comb begin
        win_next[0] = s_tdata;
        for (int k = 1; k < MAX_SIGNATURE; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_SIGNATURE; k++) begin
            slot_ok[k] = !care_aligned[k] || (win_next[k] == pat_aligned[k]);
        end
    end
    assign win_match = &slot_ok;

    assign was_sat = (cnt_reg == COUNT_MAX);
    assign cnt_inc = was_sat ? cnt_reg : cnt_reg + OFFSET_BITS'(1);

    assign hit      = !reported_reg && (cnt_inc >= OFFSET_BITS'(sig_len)) && win_match;
    assign miss_end = s_tlast && !reported_reg;

    // start offset; pinned at the count limit once saturated, then clamped to 32 bits
    assign off_raw = was_sat ? COUNT_MAX : cnt_inc - OFFSET_BITS'(sig_len);
    assign off_ext = OFF_EXT_W'(off_raw);
    assign off_out = (off_ext > OFF_EXT_W'(32'hFFFF_FFFF)) ? '1 : off_ext[OUT_OFF_W-1:0];

    always_comb begin
        cnt_next      = cnt_reg;
        reported_next = reported_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        found_next    = found_reg;
        off_next      = off_reg;
        closes_next   = closes_reg;
        if (accept) begin
            cnt_next      = s_tlast ? '0 : cnt_inc;
            reported_next = s_tlast ? 1'b0 : (reported_reg || hit);
            if (hit || miss_end) begin
                m_valid_next = 1'b1;
                found_next   = hit;
                off_next     = hit ? off_out : '0;
                closes_next  = s_tlast;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
        found_reg  <= found_next;
        off_reg    <= off_next;
        closes_reg <= closes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            reported_reg <= reported_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = off_reg;
    assign m_tlast  = closes_reg;

    // region end leaves the scanner clean for the next region
    a_region_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (cnt_reg == '0 && !reported_reg))
        else $error("region state not cleared after region end");

    // a no-match result only ever comes on the last byte, with offset zero
    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("no-match result malformed");

    // at most one match per region: a reported region yields no new result
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && reported_reg) |=> !(m_tvalid && $past(s_tready) && !$past(m_valid_reg)))
        else $error("second result in one region");

    // input only stalls when a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without pending result");

endmodule

// ----- tb/tb_masked_byte_pattern_matcher.sv -----
// Self-checking testbench for the masked byte pattern matcher: directed rows, then random regions.
`timescale 1ns / 100ps

module tb_masked_byte_pattern_matcher;
    import mbpm_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no accepted request at all
    localparam int LONG_HOLD   = 300;   // receiver back-pressure stretch
    localparam int ITEMS_PER_SETTING = 230;

    // one result as seen on the m_ stream
    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] offset;
        logic                 closes;
    } report_t;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;
    // how the expected result of a byte row is obtained
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_mode_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] value;
        logic [DATA_W-1:0]     data;
        logic                  last;
        chk_mode_t             chk;
        report_t               typed;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;     // [7:0] data_byte
    logic                  s_tlast = 1'b0;   // region_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_OFF_W-1:0]  m_tdata;          // [31:0] match_offset
    logic                  m_tuser;          // [0] found
    logic                  m_tlast;          // closes_region
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    masked_byte_pattern_matcher uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scanner model: window, byte counter, first-match flag, registers
    // ---------------------------------------------------------------
    logic [DATA_W-1:0]    win_q [0:SIG_BYTES-1];
    logic [31:0]          seen_cnt;
    logic                 reported;
    logic [8*SIG_BYTES-1:0] sig_model;   // byte j at [8j+7:8j]
    logic [CARE_W-1:0]    care_model;
    logic [LEN_W-1:0]     len_model;

    report_t pending_reports[$];
    int      mismatches = 0;
    int      stall_cycles = 0;

    // Shifts one byte in and returns 1 when it yields a result.
    function automatic logic scan_byte(input logic [DATA_W-1:0] b, input logic last,
                                       output report_t r);
        int   n;
        int   k;
        logic sat;
        logic hit;
        n = int'(len_model);
        if (n < 1) n = 1;                 // length zero acts as one
        if (n > SIG_BYTES) n = SIG_BYTES; // oversize length clamps
        sat = (seen_cnt == '1);
        for (k = SIG_BYTES - 1; k > 0; k--) win_q[k] = win_q[k-1];
        win_q[0] = b;
        if (!sat) seen_cnt++;
        r = '0;
        scan_byte = 1'b0;
        if (!reported && seen_cnt >= n) begin
            hit = 1'b1;
            // window is newest first, signature oldest first
            for (k = 0; k < n; k++)
                if (care_model[k] && sig_model[8*k +: 8] != win_q[n-1-k]) hit = 1'b0;
            if (hit) begin
                reported  = 1'b1;
                r.found   = 1'b1;
                r.offset  = sat ? '1 : seen_cnt - n;
                r.closes  = last;
                scan_byte = 1'b1;
            end
        end
        if (!scan_byte && last && !reported) begin
            r.closes  = 1'b1;            // region ended without a match
            scan_byte = 1'b1;
        end
        if (last) begin
            for (k = 0; k < SIG_BYTES; k++) win_q[k] = '0;
            seen_cnt = '0;
            reported = 1'b0;
        end
    endfunction

    // check mode of the byte currently offered; travels with s_tvalid
    chk_mode_t row_chk = CHK_MODEL;
    report_t   row_typed = '0;

    // ---------------------------------------------------------------
    // Monitor: check results, track register writes, predict on bytes
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        report_t want;
        report_t got;
        logic    produced;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result: found %0d offset %0d closes %0d",
                           m_tuser, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== want.offset) begin
                        $error("match_offset: expected %0d, got %0d", want.offset, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.closes) begin
                        $error("closes_region: expected %0d, got %0d", want.closes, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_SIG_A:  sig_model[63:0]    = cfg_data;
                    CFG_SIG_B:  sig_model[127:64]  = cfg_data;
                    CFG_SIG_C:  sig_model[191:128] = cfg_data;
                    CFG_SIG_D:  sig_model[255:192] = cfg_data;
                    CFG_CARE:   care_model = cfg_data[CARE_W-1:0];
                    CFG_LENGTH: len_model  = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                produced = scan_byte(s_tdata, s_tlast, got);
                case (row_chk)
                    CHK_MODEL: if (produced) pending_reports = {pending_reports, got};
                    CHK_TYPED: pending_reports = {pending_reports, row_typed};
                    default: ;
                endcase
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random ready, plus a long hold when asked for
    // ---------------------------------------------------------------
    int src_idle_pct = 17;
    int dst_idle_pct = 56;
    int hold_token = 0;
    int hold_served = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (hold_token != hold_served) begin
            hold_served = hold_token;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offers one byte, with random idle cycles ahead; leaves tvalid high.
    task automatic send_byte(input logic [DATA_W-1:0] b, input logic last,
                             input chk_mode_t chk, input report_t typed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= last;
        row_chk   <= chk;
        row_typed <= typed;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait for every pending result.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    // Drained, plus the pipeline latency for bytes that give no result.
    task automatic quiesce();
        drain();
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    row_t stim_rows[$];

    function automatic void add_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r       = '0;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = val;
        stim_rows = {stim_rows, r};
    endfunction

    function automatic void add_byte(input logic [DATA_W-1:0] b, input logic last,
                                     input chk_mode_t chk, input logic found,
                                     input logic closes);
        row_t r;
        r              = '0;
        r.kind         = ROW_BYTE;
        r.data         = b;
        r.last         = last;
        r.chk          = chk;
        r.typed.found  = found;
        r.typed.closes = closes;  // typed offsets are all zero
        stim_rows = {stim_rows, r};
    endfunction

    // settings of the current random phase, used to plant signatures
    logic [8*SIG_BYTES-1:0] plan_sig;
    logic [CARE_W-1:0]      plan_care;
    logic [LEN_W-1:0]       plan_len;
    int                     plan_eff;

    initial begin : stimulus
        logic [DATA_W-1:0] region_bytes[$];
        int s, i, j, n, r, pos, sent;
        for (i = 0; i < SIG_BYTES; i++) win_q[i] = '0;
        seen_cnt   = '0;
        reported   = 1'b0;
        sig_model  = '0;
        care_model = '0;
        len_model  = 6'd1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows. After reset everything is wildcard with length 1,
        // so the first byte of a region matches at offset 0.
        add_byte(8'h00, 1'b0, CHK_TYPED, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, CHK_NONE,  1'b0, 1'b0);   // match already reported
        add_byte(8'hA5, 1'b1, CHK_TYPED, 1'b1, 1'b1);
        add_reg(CFG_LENGTH, 64'd0);                     // zero length acts as one
        add_byte(8'h11, 1'b1, CHK_TYPED, 1'b1, 1'b1);
        add_reg(CFG_LENGTH, 64'd63);                    // oversize, clamps to 32
        add_byte(8'h01, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'h02, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'h03, 1'b1, CHK_TYPED, 1'b0, 1'b1);   // shorter than signature
        // exact signature DE AD BE EF
        add_reg(CFG_SIG_A, 64'h0000_0000_EFBE_ADDE);
        add_reg(CFG_CARE, 64'h0000_0000_0000_000F);
        add_reg(CFG_LENGTH, 64'd4);
        add_byte(8'h00, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hDE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hAD, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hBE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hEF, 1'b0, CHK_MODEL, 1'b0, 1'b0);   // first match, offset 1
        add_byte(8'h11, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hDE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hAD, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hBE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hEF, 1'b1, CHK_MODEL, 1'b0, 1'b0);   // later match dropped
        // byte 1 wildcard; care bits past the length are set but unused
        add_reg(CFG_CARE, 64'h0000_0000_FFFF_FFFD);
        add_byte(8'hDE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'h77, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hBE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hEF, 1'b1, CHK_MODEL, 1'b0, 1'b0);   // match ends on last byte
        // short regions must not see bytes of the previous region
        add_byte(8'hBE, 1'b0, CHK_MODEL, 1'b0, 1'b0);
        add_byte(8'hEF, 1'b1, CHK_TYPED, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b1, CHK_TYPED, 1'b0, 1'b1);

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_REG) begin
                quiesce();
                write_reg(stim_rows[k].idx, stim_rows[k].value);
            end else begin
                send_byte(stim_rows[k].data, stim_rows[k].last,
                          stim_rows[k].chk, stim_rows[k].typed);
            end
        end

        // Random part: three idle phases, two register settings each.
        for (s = 0; s < 6; s++) begin
            case (s / 2)
                0:       begin src_idle_pct = 17; dst_idle_pct = 56; end
                1:       begin src_idle_pct = 56; dst_idle_pct = 17; end
                default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
            endcase
            for (i = 0; i < 8; i++) plan_sig[32*i +: 32] = $urandom;
            case (s)
                0:       begin plan_len = 6'd1;  plan_care = '1; end
                1:       begin plan_len = 6'd32; plan_care = '1; end
                2:       begin plan_len = 6'd0;  plan_care = '0; end
                3:       begin plan_len = 6'($urandom_range(2, 12));  plan_care = $urandom | $urandom; end
                4:       begin plan_len = 6'd63; plan_care = $urandom | $urandom; end
                default: begin plan_len = 6'($urandom_range(13, 31)); plan_care = $urandom; end
            endcase
            plan_eff = (plan_len == 0) ? 1 : (plan_len > SIG_BYTES) ? SIG_BYTES : int'(plan_len);

            // registers only change at a region boundary with nothing in flight
            quiesce();
            write_reg(CFG_SIG_A, plan_sig[63:0]);
            write_reg(CFG_SIG_B, plan_sig[127:64]);
            write_reg(CFG_SIG_C, plan_sig[191:128]);
            write_reg(CFG_SIG_D, plan_sig[255:192]);
            write_reg(CFG_CARE, {$urandom, plan_care});        // upper bits ignored
            write_reg(CFG_LENGTH, {$urandom, 26'($urandom), plan_len});

            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
                r = $urandom_range(99);
                if (r < 75)      n = $urandom_range(plan_eff, plan_eff + 20);
                else if (r < 90) n = $urandom_range(1, plan_eff);
                else             n = $urandom_range(plan_eff + 20, 120);
                // filler leans on signature bytes to provoke partial matches
                region_bytes = {};
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(9) < 3)
                        region_bytes = {region_bytes,
                                        plan_sig[8*$urandom_range(0, plan_eff-1) +: 8]};
                    else
                        region_bytes = {region_bytes, 8'($urandom_range(255))};
                end
                r = $urandom_range(99);
                if (n >= plan_eff && r < 80) begin
                    pos = $urandom_range(0, n - plan_eff);
                    for (j = 0; j < plan_eff; j++)
                        if (plan_care[j]) region_bytes[pos+j] = plan_sig[8*j +: 8];
                    if (r >= 65) begin
                        // broken signature: spoil one cared byte
                        j = $urandom_range(0, plan_eff - 1);
                        if (plan_care[j]) region_bytes[pos+j] = ~plan_sig[8*j +: 8];
                    end
                end
                for (i = 0; i < n; i++) begin
                    send_byte(region_bytes[i], i == n - 1, CHK_MODEL, '0);
                    sent++;
                    // long receiver hold while bytes keep coming
                    if (sent == 60) hold_token <= hold_token + 1;
                    // occasional pause mid-region until all results are in
                    if (i != n - 1 && $urandom_range(99) == 0) drain();
                end
            end
        end

        quiesce();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- masked_byte_pattern_matcher.f -----
rtl/core/mbpm_pkg.sv
rtl/core/mbpm_cfg.sv
rtl/core/masked_byte_pattern_matcher.sv
tb/tb_masked_byte_pattern_matcher.sv
